FILE: hdl/mbsb_pkg.sv
// ----------------------------------------------------------------------------
// mbsb_pkg
// Shared types and constants for the scaled 1bpp bitmap expander.
// ----------------------------------------------------------------------------
package mbsb_pkg;

    localparam int BYTE_W      = 8;
    localparam int BIT_W       = 3;
    localparam int DIM_REG_W   = 11;
    localparam int SCALE_REG_W = 4;
    localparam int ORIGIN_W    = 12;
    localparam int COLOR_W     = 32;
    localparam int COORD_W     = 14;
    localparam int LEN_W       = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [BIT_W-1:0] FIRST_BIT = 3'd7;
    localparam logic [BIT_W-1:0] LAST_BIT  = 3'd0;

    localparam logic [DIM_REG_W-1:0]   RST_FRAME_WIDTH  = 11'd128;
    localparam logic [DIM_REG_W-1:0]   RST_FRAME_HEIGHT = 11'd96;
    localparam logic [SCALE_REG_W-1:0] RST_SCALE        = 4'd3;
    localparam logic [ORIGIN_W-1:0]    RST_ORIGIN_X     = 12'd20;
    localparam logic [ORIGIN_W-1:0]    RST_ORIGIN_Y     = 12'd40;
    localparam logic [COLOR_W-1:0]     RST_COLOR_SET    = 32'hFFFF_FFFF;
    localparam logic [COLOR_W-1:0]     RST_COLOR_CLEAR  = 32'hFF00_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_SCALE_FACTOR = 3'd2,
        REG_ORIGIN_X     = 3'd3,
        REG_ORIGIN_Y     = 3'd4,
        REG_COLOR_SET    = 3'd5,
        REG_COLOR_CLEAR  = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [ORIGIN_W-1:0] origin_x;
        logic [ORIGIN_W-1:0] origin_y;
        logic [COLOR_W-1:0]  color_set;
        logic [COLOR_W-1:0]  color_clear;
    } cfg_static_t;

endpackage

FILE: hdl/mbsb_cfg.sv
// ----------------------------------------------------------------------------
// mbsb_cfg
// Configuration registers with clamping of dimensions and scale.
// ----------------------------------------------------------------------------
module mbsb_cfg #(
    parameter int MAX_SCALE     = 8,
    parameter int MAX_DIMENSION = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [mbsb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mbsb_pkg::CFG_DATA_W-1:0]      cfg_data,
    output mbsb_pkg::cfg_static_t                cfg_static,
    output logic [$clog2(MAX_DIMENSION):0]       eff_w,
    output logic [$clog2(MAX_DIMENSION):0]       eff_h,
    output logic [$clog2(MAX_SCALE+1)-1:0]       eff_s
);
    import mbsb_pkg::*;

    localparam int DW = $clog2(MAX_DIMENSION) + 1;
    localparam int SW = $clog2(MAX_SCALE + 1);

    logic [DIM_REG_W-1:0]   frame_width_reg;
    logic [DIM_REG_W-1:0]   frame_height_reg;
    logic [SCALE_REG_W-1:0] scale_factor_reg;
    logic [ORIGIN_W-1:0]    origin_x_reg;
    logic [ORIGIN_W-1:0]    origin_y_reg;
    logic [COLOR_W-1:0]     color_set_reg;
    logic [COLOR_W-1:0]     color_clear_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            scale_factor_reg <= RST_SCALE;
            origin_x_reg     <= RST_ORIGIN_X;
            origin_y_reg     <= RST_ORIGIN_Y;
            color_set_reg    <= RST_COLOR_SET;
            color_clear_reg  <= RST_COLOR_CLEAR;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[DIM_REG_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[DIM_REG_W-1:0];
                REG_SCALE_FACTOR: scale_factor_reg <= cfg_data[SCALE_REG_W-1:0];
                REG_ORIGIN_X:     origin_x_reg     <= cfg_data[ORIGIN_W-1:0];
                REG_ORIGIN_Y:     origin_y_reg     <= cfg_data[ORIGIN_W-1:0];
                REG_COLOR_SET:    color_set_reg    <= cfg_data[COLOR_W-1:0];
                REG_COLOR_CLEAR:  color_clear_reg  <= cfg_data[COLOR_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        priority if (frame_width_reg == '0)
            eff_w = DW'(1);
        else if (32'(frame_width_reg) > MAX_DIMENSION)
            eff_w = DW'(MAX_DIMENSION);
        else
            eff_w = DW'(frame_width_reg);

        priority if (frame_height_reg == '0)
            eff_h = DW'(1);
        else if (32'(frame_height_reg) > MAX_DIMENSION)
            eff_h = DW'(MAX_DIMENSION);
        else
            eff_h = DW'(frame_height_reg);

        priority if (scale_factor_reg == '0)
            eff_s = SW'(1);
        else if (32'(scale_factor_reg) > MAX_SCALE)
            eff_s = SW'(MAX_SCALE);
        else
            eff_s = SW'(scale_factor_reg);
    end

    assign cfg_static.origin_x    = origin_x_reg;
    assign cfg_static.origin_y    = origin_y_reg;
    assign cfg_static.color_set   = color_set_reg;
    assign cfg_static.color_clear = color_clear_reg;

endmodule

FILE: hdl/mbsb_fifo.sv
// ----------------------------------------------------------------------------
// mbsb_fifo
// Short byte queue between the input side and the run generator.
// ----------------------------------------------------------------------------
module mbsb_fifo (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push_valid,
    output logic                          push_ready,
    input  logic [mbsb_pkg::BYTE_W-1:0]   push_data,
    output logic                          pop_valid,
    input  logic                          pop_ready,
    output logic [mbsb_pkg::BYTE_W-1:0]   pop_data
);
    import mbsb_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    logic [BYTE_W-1:0] slot_reg [QUEUE_DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [AW:0]       count_reg, count_next;
    logic              push, pop;

    assign push_ready = (count_reg != (AW+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: hdl/mbsb_expand.sv
// ----------------------------------------------------------------------------
// mbsb_expand
// Run generator: walks bits 7..0 of a byte and the block rows of each pixel,
// one run per cycle unless run_ready stalls the output, tracks column/row position, output register.
// ----------------------------------------------------------------------------
module mbsb_expand #(
    parameter int MAX_SCALE     = 8,
    parameter int MAX_DIMENSION = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mbsb_pkg::cfg_static_t              cfg_static,
    input  logic [$clog2(MAX_DIMENSION):0]     eff_w,
    input  logic [$clog2(MAX_DIMENSION):0]     eff_h,
    input  logic [$clog2(MAX_SCALE+1)-1:0]     eff_s,
    input  logic                               byte_valid,
    output logic                               byte_ready,
    input  logic [mbsb_pkg::BYTE_W-1:0]        byte_data,
    output logic                               run_valid,
    input  logic                               run_ready,
    output logic [mbsb_pkg::COORD_W-1:0]       run_x,
    output logic [mbsb_pkg::COORD_W-1:0]       run_y,
    output logic [mbsb_pkg::LEN_W-1:0]         run_length,
    output logic [mbsb_pkg::COLOR_W-1:0]       run_color,
    output logic                               byte_done,
    output logic                               frame_done
);
    import mbsb_pkg::*;

    localparam int CW = $clog2(MAX_DIMENSION);
    localparam int SW = $clog2(MAX_SCALE + 1);

    logic              active_reg, active_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic [SW-1:0]     r_reg, r_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [CW-1:0]     row_reg, row_next;

    logic               out_valid_reg, out_valid_next;
    logic [COORD_W-1:0] x_reg, y_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [COLOR_W-1:0] color_reg;
    logic               bdone_reg, fdone_reg;

    logic               emit, last_row, last_col, last_pix, byte_end, load;
    logic [SW:0]        r_inc;
    logic [CW:0]        col_inc, row_inc;
    logic [COORD_W-1:0] cur_x, cur_y;
    logic [COLOR_W-1:0] cur_color;

    always_comb
    begin
        emit     = active_reg && (!out_valid_reg || run_ready);
        r_inc    = {1'b0, r_reg} + (SW+1)'(1);
        col_inc  = {1'b0, col_reg} + (CW+1)'(1);
        row_inc  = {1'b0, row_reg} + (CW+1)'(1);
        last_row = (r_inc == {1'b0, eff_s});
        last_col = (col_inc >= eff_w);
        last_pix = last_col && (row_inc >= eff_h);
        byte_end = emit && last_row && (bit_reg == LAST_BIT);
        byte_ready = !active_reg || byte_end;
        load     = byte_valid && byte_ready;

        cur_x = COORD_W'(cfg_static.origin_x) + COORD_W'(col_reg) * COORD_W'(eff_s);
        cur_y = COORD_W'(cfg_static.origin_y) + COORD_W'(row_reg) * COORD_W'(eff_s)
              + COORD_W'(r_reg);
        cur_color = byte_reg[bit_reg] ? cfg_static.color_set : cfg_static.color_clear;

        active_next = active_reg;
        byte_next   = byte_reg;
        bit_next    = bit_reg;
        r_next      = r_reg;
        col_next    = col_reg;
        row_next    = row_reg;

        if (emit)
        begin
            if (!last_row)
                r_next = r_inc[SW-1:0];
            else
            begin
                r_next = '0;
                if (last_col)
                begin
                    col_next = '0;
                    row_next = (row_inc >= eff_h) ? '0 : row_inc[CW-1:0];
                end
                else
                    col_next = col_inc[CW-1:0];
                if (bit_reg == LAST_BIT)
                    active_next = 1'b0;
                else
                    bit_next = bit_reg - BIT_W'(1);
            end
        end

        if (load)
        begin
            active_next = 1'b1;
            byte_next   = byte_data;
            bit_next    = FIRST_BIT;
        end

        if (emit)
            out_valid_next = 1'b1;
        else if (run_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            bit_reg       <= FIRST_BIT;
            r_reg         <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            bit_reg       <= bit_next;
            r_reg         <= r_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        if (emit)
        begin
            x_reg     <= cur_x;
            y_reg     <= cur_y;
            len_reg   <= LEN_W'(eff_s);
            color_reg <= cur_color;
            bdone_reg <= last_row && (bit_reg == LAST_BIT);
            fdone_reg <= last_row && last_pix;
        end
    end

    assign run_valid  = out_valid_reg;
    assign run_x      = x_reg;
    assign run_y      = y_reg;
    assign run_length = len_reg;
    assign run_color  = color_reg;
    assign byte_done  = bdone_reg;
    assign frame_done = fdone_reg;

endmodule

FILE: hdl/mono_bitmap_scaled_blitter.sv
// ----------------------------------------------------------------------------
// mono_bitmap_scaled_blitter
// Expands packed 1bpp frame bytes into scaled horizontal color runs.
//
//   channel  signals                              direction
//   frame    frame_valid/frame_ready, frame_byte  in
//   run      run_valid/run_ready, run_*, *_done   out
//   cfg      cfg_write, cfg_index, cfg_data       in (write only)
//
// One run per cycle from the run generator unless the run output is stalled: a byte gives 8*scale runs
// (24 at the reset scale), back to back across bytes.
// A 4-byte queue decouples input acceptance from run generation.
// Output register: a stalled run does not block the queue from filling.
// No clearing pass after reset; items accepted from the first cycle.
// ----------------------------------------------------------------------------
module mono_bitmap_scaled_blitter #(
    parameter int MAX_SCALE     = 8,
    parameter int MAX_DIMENSION = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [mbsb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mbsb_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              frame_valid,
    output logic                              frame_ready,
    input  logic [mbsb_pkg::BYTE_W-1:0]       frame_byte,
    output logic                              run_valid,
    input  logic                              run_ready,
    output logic [mbsb_pkg::COORD_W-1:0]      run_x,
    output logic [mbsb_pkg::COORD_W-1:0]      run_y,
    output logic [mbsb_pkg::LEN_W-1:0]        run_length,
    output logic [mbsb_pkg::COLOR_W-1:0]      run_color,
    output logic                              byte_done,
    output logic                              frame_done
);
    import mbsb_pkg::*;

    localparam int DW = $clog2(MAX_DIMENSION) + 1;
    localparam int SW = $clog2(MAX_SCALE + 1);

    cfg_static_t       cfg_static;
    logic [DW-1:0]     eff_w, eff_h;
    logic [SW-1:0]     eff_s;
    logic              q_valid, q_ready;
    logic [BYTE_W-1:0] q_data;

    mbsb_cfg #(
        .MAX_SCALE     (MAX_SCALE),
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg_static (cfg_static),
        .eff_w      (eff_w),
        .eff_h      (eff_h),
        .eff_s      (eff_s)
    );

    mbsb_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (frame_valid),
        .push_ready (frame_ready),
        .push_data  (frame_byte),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    mbsb_expand #(
        .MAX_SCALE     (MAX_SCALE),
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_expand (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_static (cfg_static),
        .eff_w      (eff_w),
        .eff_h      (eff_h),
        .eff_s      (eff_s),
        .byte_valid (q_valid),
        .byte_ready (q_ready),
        .byte_data  (q_data),
        .run_valid  (run_valid),
        .run_ready  (run_ready),
        .run_x      (run_x),
        .run_y      (run_y),
        .run_length (run_length),
        .run_color  (run_color),
        .byte_done  (byte_done),
        .frame_done (frame_done)
    );

endmodule

FILE: hdl/mbsb_checker.sv
// ----------------------------------------------------------------------------
// mbsb_checker
// Port-level checks for the blitter, bound to the top level.
// ----------------------------------------------------------------------------
module mbsb_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              frame_valid,
    input  logic                              frame_ready,
    input  logic                              run_valid,
    input  logic                              run_ready,
    input  logic [mbsb_pkg::COORD_W-1:0]      run_x,
    input  logic [mbsb_pkg::COORD_W-1:0]      run_y,
    input  logic [mbsb_pkg::LEN_W-1:0]        run_length,
    input  logic [mbsb_pkg::COLOR_W-1:0]      run_color,
    input  logic                              byte_done,
    input  logic                              frame_done
);
    import mbsb_pkg::*;

    logic               run_acc, frame_acc;
    logic [LEN_W-1:0]   row_in_pix_reg;
    logic [COORD_W-1:0] prev_x_reg, prev_y_reg;
    logic [COLOR_W-1:0] prev_color_reg;
    logic [3:0]         pending_reg;

    assign run_acc   = run_valid && run_ready;
    assign frame_acc = frame_valid && frame_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_in_pix_reg <= '0;
            pending_reg    <= '0;
        end
        else
        begin
            if (run_acc)
                row_in_pix_reg <= (row_in_pix_reg + LEN_W'(1) == run_length) ?
                                  '0 : row_in_pix_reg + LEN_W'(1);
            pending_reg <= pending_reg + 4'(frame_acc) - 4'(run_acc && byte_done);
        end
    end

    always_ff @(posedge clk)
    begin
        if (run_acc)
        begin
            prev_x_reg     <= run_x;
            prev_y_reg     <= run_y;
            prev_color_reg <= run_color;
        end
    end

    // stalled run holds
    assert property (@(posedge clk) disable iff (!rst_n)
        run_valid && !run_ready |=> run_valid && $stable(run_x) && $stable(run_y)
            && $stable(run_color) && $stable(byte_done) && $stable(frame_done))
        else $error("run changed while stalled");

    // no run without an outstanding byte
    assert property (@(posedge clk) disable iff (!rst_n)
        run_valid |-> pending_reg != '0)
        else $error("run with no byte outstanding");

    // rows of one block are stacked under each other in one color
    assert property (@(posedge clk) disable iff (!rst_n)
        run_acc && row_in_pix_reg != '0 |-> run_x == prev_x_reg
            && run_y == prev_y_reg + COORD_W'(1) && run_color == prev_color_reg)
        else $error("block rows not contiguous");

    // byte and frame completion only on a block's last row
    assert property (@(posedge clk) disable iff (!rst_n)
        run_acc && (byte_done || frame_done) |->
            row_in_pix_reg + LEN_W'(1) == run_length)
        else $error("done flag inside a block");

endmodule

bind mono_bitmap_scaled_blitter mbsb_checker u_mbsb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .run_valid   (run_valid),
    .run_ready   (run_ready),
    .run_x       (run_x),
    .run_y       (run_y),
    .run_length  (run_length),
    .run_color   (run_color),
    .byte_done   (byte_done),
    .frame_done  (frame_done)
);
